### hdl/ftfpc_pkg.sv
// Package for the five-tuple flow packet counter.
// Holds table size, status codes, header field values and the key type; no dependencies.
`default_nettype none
package ftfpc_pkg;
	localparam int TableEntries = 1024;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = IdxW + 1;

	localparam logic [2:0] StHit      = 3'd0;
	localparam logic [2:0] StNew      = 3'd1;
	localparam logic [2:0] StNotIpv4  = 3'd2;
	localparam logic [2:0] StTrunc    = 3'd3;
	localparam logic [2:0] StFull     = 3'd4;

	localparam logic [7:0]  ProtoTcp  = 8'd6;
	localparam logic [7:0]  ProtoUdp  = 8'd17;
	localparam logic [15:0] EtherIpv4 = 16'h0800;
	localparam logic [5:0]  PosMax    = 6'd63;

	typedef struct packed {
		logic [63:0] addr;
		logic [39:0] pp;
	} key_t;
endpackage
`default_nettype wire

### hdl/ftfpc_table.sv
// Flow table with sequential search: filled entries are read and compared one at a time.
// Depends on ftfpc_pkg.
`default_nettype none
module ftfpc_table (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire ftfpc_pkg::key_t    key,
	output logic                    done,
	output logic [2:0]              status,
	output logic [63:0]             count
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_WB   = 3'd3;

	logic [2:0] state_q;
	logic [ftfpc_pkg::CntW-1:0] idx_q;
	logic [ftfpc_pkg::CntW-1:0] fill_q;
	ftfpc_pkg::key_t key_q;

	ftfpc_pkg::key_t keymem [ftfpc_pkg::TableEntries];
	logic [63:0] cntmem [ftfpc_pkg::TableEntries];
	ftfpc_pkg::key_t rd_key_q;
	logic [63:0] rd_cnt_q;
	logic [ftfpc_pkg::IdxW-1:0] rd_idx_q;
	logic [63:0] inc_q;

	logic [ftfpc_pkg::IdxW-1:0] ridx;
	logic tfull;
	assign ridx = idx_q[ftfpc_pkg::IdxW-1:0];
	assign tfull = fill_q == ftfpc_pkg::CntW'(ftfpc_pkg::TableEntries);

	always_ff @(posedge clk) begin
		rd_key_q <= keymem[ridx];
		rd_cnt_q <= cntmem[ridx];
		if (state_q == S_CMP && rd_key_q == key_q) begin
			cntmem[rd_idx_q] <= rd_cnt_q + 64'd1;
		end else if (state_q == S_RD && idx_q == fill_q && !tfull) begin
			keymem[fill_q[ftfpc_pkg::IdxW-1:0]] <= key_q;
			cntmem[fill_q[ftfpc_pkg::IdxW-1:0]] <= 64'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			fill_q <= '0;
			rd_idx_q <= '0;
			done <= 1'b0;
			status <= ftfpc_pkg::StHit;
			count <= '0;
			key_q <= '0;
			inc_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= key;
						idx_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (idx_q == fill_q) begin
						done <= 1'b1;
						state_q <= S_IDLE;
						if (!tfull) begin
							status <= ftfpc_pkg::StNew;
							count <= 64'd1;
							fill_q <= fill_q + 1'b1;
						end else begin
							status <= ftfpc_pkg::StFull;
							count <= '0;
						end
					end else begin
						rd_idx_q <= ridx;
						idx_q <= idx_q + 1'b1;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rd_key_q == key_q) begin
						inc_q <= rd_cnt_q + 64'd1;
						state_q <= S_WB;
					end else begin
						state_q <= S_RD;
					end
				end
				S_WB: begin
					done <= 1'b1;
					status <= ftfpc_pkg::StHit;
					count <= inc_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	assert property (@(posedge clk) disable iff (!arst_n)
		start && state_q == S_IDLE |=> state_q == S_RD) else $error("no search");
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ftfpc_pkg::StNew |-> count == 64'd1) else $error("new count");
endmodule
`default_nettype wire

### hdl/five_tuple_flow_packet_counter_unit.sv
// Top level: header capture of streamed frames and result output register.
// Depends on ftfpc_pkg and ftfpc_table.
// A qualifying frame's last byte starts a search of the filled entries, read and compared
// one at a time; the result follows the write-back on a hit, or the end of the filled
// entries on a miss or with a full table; s_tready low until it transfers.
// Other frames give their result in the cycle after the last byte. Reset clears the capture
// registers and the table fill count; entries past the fill count are never compared.
`default_nettype none
module five_tuple_flow_packet_counter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // packet_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata    // status[2:0], flow_count[66:3], zero fill
);
	logic [5:0] pos_q;
	logic [15:0] eth_q;
	logic [7:0] proto_q;
	logic [63:0] addr_q;
	logic [31:0] ports_q;
	logic busy_q;
	logic start;
	logic tdone;
	logic [2:0] tstatus;
	logic [63:0] tcount;
	ftfpc_pkg::key_t key;

	logic xfer;
	logic [15:0] eth_n;
	logic [7:0] proto_n;
	logic [63:0] addr_n;
	logic [31:0] ports_n;
	logic [6:0] len;
	logic [2:0] early;
	logic qual;

	assign s_tready = !busy_q && !m_tvalid;
	assign xfer = s_tvalid && s_tready;

	always_comb begin
		eth_n = eth_q;
		proto_n = proto_q;
		addr_n = addr_q;
		ports_n = ports_q;
		if (pos_q == 6'd12 || pos_q == 6'd13) eth_n = {eth_q[7:0], s_tdata};
		else if (pos_q == 6'd23) proto_n = s_tdata;
		else if (pos_q >= 6'd26 && pos_q <= 6'd33) addr_n = {addr_q[55:0], s_tdata};
		else if (pos_q >= 6'd34 && pos_q <= 6'd37) ports_n = {ports_q[23:0], s_tdata};
		len = {1'b0, pos_q} + 7'd1;
		qual = 1'b0;
		early = ftfpc_pkg::StTrunc;
		if (len < 7'd14) early = ftfpc_pkg::StTrunc;
		else if (eth_n != ftfpc_pkg::EtherIpv4) early = ftfpc_pkg::StNotIpv4;
		else if (len < 7'd34) early = ftfpc_pkg::StTrunc;
		else if (proto_n == ftfpc_pkg::ProtoTcp && len < 7'd54) early = ftfpc_pkg::StTrunc;
		else if (proto_n == ftfpc_pkg::ProtoUdp && len < 7'd42) early = ftfpc_pkg::StTrunc;
		else qual = 1'b1;
		key.addr = addr_n;
		key.pp = {(proto_n == ftfpc_pkg::ProtoTcp || proto_n == ftfpc_pkg::ProtoUdp)
			? ports_n : 32'd0, proto_n};
	end

	assign start = xfer && s_tlast && qual;

	ftfpc_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.key    (key),
		.done   (tdone),
		.status (tstatus),
		.count  (tcount)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			eth_q <= '0;
			proto_q <= '0;
			addr_q <= '0;
			ports_q <= '0;
			busy_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (xfer) begin
				eth_q <= eth_n;
				proto_q <= proto_n;
				addr_q <= addr_n;
				ports_q <= ports_n;
				if (s_tlast) begin
					pos_q <= '0;
					if (qual) begin
						busy_q <= 1'b1;
					end else begin
						m_tvalid <= 1'b1;
						m_tdata <= {5'd0, 64'd0, early};
					end
				end else if (pos_q != ftfpc_pkg::PosMax) begin
					pos_q <= pos_q + 6'd1;
				end
			end
			if (tdone) begin
				busy_q <= 1'b0;
				m_tvalid <= 1'b1;
				m_tdata <= {5'd0, tcount, tstatus};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !s_tready)
		else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n) tdone |-> busy_q)
		else $error("stray done");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("start lost");
endmodule
`default_nettype wire
